// ----- hw/rtl/ksi_pkg.sv -----
// Shared types and constants for the keyframe sampler/interpolator.
// No dependencies.
package ksi_pkg;

   localparam int unsigned DIV_BITS  = 48;
   localparam logic [16:0] LFAC_ONE  = 17'h10000;
   localparam int unsigned OUT_VALUES = 4;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_INTERP_MODE = 1'b0;
   localparam logic CSR_KEY_COUNT   = 1'b1;

   localparam logic MODE_STEP   = 1'b0;
   localparam logic MODE_LINEAR = 1'b1;

   localparam logic [1:0] ST_SAMPLED = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_ORDER   = 2'd2;
   localparam logic [1:0] ST_WRITTEN = 2'd3;

   typedef struct packed {
      logic we;
      logic cap_pv;
      logic cap_nv;
      logic do_diff;
      logic do_mul;
      logic do_add;
      logic blend;
   } lane_ctrl_type;

endpackage

// ----- hw/rtl/ksi_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle; used for time wrap
// and the lerp factor. Depends on ksi_pkg.
module ksi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [47:0] quotient,
   output logic [31:0] remainder
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [47:0] quo_ff, quo_in;
   logic [32:0] sh;
   logic        ge;

   always_comb begin
      sh      = {rem_ff, quo_ff[47]};
      ge      = sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(sh - {1'b0, dsr_ff}) : sh[31:0];
         quo_in = {quo_ff[46:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ksi_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- hw/rtl/ksi_lane.sv -----
// One component lane: its slice of the key value memory and the lerp datapath.
// Depends on ksi_pkg.
module ksi_lane #(
   parameter int unsigned MAX_KEYS = 64,
   localparam int unsigned KW = $clog2(MAX_KEYS)
) (
   input  logic                    clock,
   input  ksi_pkg::lane_ctrl_type  ctrl,
   input  logic [KW-1:0]           wr_addr,
   input  logic [31:0]             wr_data,
   input  logic [KW-1:0]           rd_addr,
   input  logic [16:0]             lfac,
   output logic [31:0]             value
);
   logic [31:0]        mem [MAX_KEYS];
   logic [31:0]        rdata_ff;
   logic signed [31:0] pv_ff, nv_ff;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [50:0] prod_ff, prod_in;
   logic [31:0]        res_ff, res_in;

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      diff_in = 33'(nv_ff) - 33'(pv_ff);
      prod_in = 51'($signed({1'b0, lfac})) * 51'(diff_ff);
      res_in  = ctrl.blend ? 32'(51'(pv_ff) + (prod_ff >>> 16)) : pv_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap_pv)  pv_ff   <= rdata_ff;
      if (ctrl.cap_nv)  nv_ff   <= rdata_ff;
      if (ctrl.do_diff) diff_ff <= diff_in;
      if (ctrl.do_mul)  prod_ff <= prod_in;
      if (ctrl.do_add)  res_ff  <= res_in;
   end

   assign value = res_ff;
endmodule

// ----- hw/rtl/keyframe_sampler_interpolator_core.sv -----
// Top level: key time memory, bracket search sequencer, divider, value lanes
// and the merging output register. Depends on ksi_pkg, ksi_div, ksi_lane.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | opcode, key, sample fields
//   rsp     | out       | rsp_valid/rsp_ready  | status, value_0..3
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Accept to next accept: a key write only passes the output state; a sample
// grows with its bracket key, plus a serial divide each for a wrapped time
// and the lerp factor; the linear key search and the divider dominate.
// Reset is synchronous; it clears control state, key storage stays undefined.
// One item is in flight; a pending result stalls only the final beat.
module keyframe_sampler_interpolator_core #(
   parameter int unsigned MAX_KEYS   = 64,
   parameter int unsigned COMPONENTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [5:0]  req_key_index,
   input  logic [31:0] req_key_time,
   input  logic [31:0] req_key_value_0,
   input  logic [31:0] req_key_value_1,
   input  logic [31:0] req_key_value_2,
   input  logic [31:0] req_key_value_3,
   input  logic [31:0] req_sample_time,
   input  logic        req_loop_enable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_0,
   output logic [31:0] rsp_value_1,
   output logic [31:0] rsp_value_2,
   output logic [31:0] rsp_value_3,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);
   localparam int unsigned KW = $clog2(MAX_KEYS);
   localparam int unsigned NW = $clog2(MAX_KEYS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_END   = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_MOD   = 4'd3;
   localparam logic [3:0] S_SRD   = 4'd4;
   localparam logic [3:0] S_SCMP  = 4'd5;
   localparam logic [3:0] S_LDIV  = 4'd6;
   localparam logic [3:0] S_VP    = 4'd7;
   localparam logic [3:0] S_VN    = 4'd8;
   localparam logic [3:0] S_VC    = 4'd9;
   localparam logic [3:0] S_DIFF  = 4'd10;
   localparam logic [3:0] S_MUL   = 4'd11;
   localparam logic [3:0] S_ADD   = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic        mode_ff;
   logic [6:0]  kcount_ff;
   logic [NW-1:0] n_cur, n_ff, n_in;
   logic [KW-1:0] last_ff, last_in, i_ff, i_in, prev_ff, prev_in, next_ff, next_in;
   logic [KW-1:0] t_raddr, wr_addr;
   logic [31:0] tmem [MAX_KEYS];
   logic [31:0] t_rdata_ff;
   logic [31:0] endt_ff, endt_in, t_ff, t_in, tprev_ff, tprev_in;
   logic [31:0] samp_ff, samp_in;
   logic        loop_ff, loop_in, blend_ff, blend_in;
   logic [1:0]  status_ff, status_in;
   logic [16:0] lfac_ff, lfac_in;
   logic        wr_ok, accept, mem_we;
   logic        div_start, div_busy, div_done;
   logic [47:0] div_dvd, div_quo;
   logic [31:0] div_dsr, div_rem;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_val_ff [ksi_pkg::OUT_VALUES];
   logic [31:0] lane_val [ksi_pkg::OUT_VALUES];
   logic [31:0] key_val [ksi_pkg::OUT_VALUES];
   logic        load_out;
   ksi_pkg::lane_ctrl_type lctrl;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ksi_pkg::MODE_LINEAR;
         kcount_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ksi_pkg::CSR_INTERP_MODE: mode_ff   <= csr_data[0];
            ksi_pkg::CSR_KEY_COUNT:   kcount_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_ok     = {26'b0, req_key_index} < 32'(MAX_KEYS);
   assign mem_we    = accept && (req_opcode == ksi_pkg::OP_WRITE) && wr_ok;
   assign wr_addr   = KW'({26'b0, req_key_index});
   assign n_cur     = ({25'b0, kcount_ff} > 32'(MAX_KEYS)) ? NW'(MAX_KEYS)
                                                          : NW'({25'b0, kcount_ff});
   assign key_val[0] = req_key_value_0;
   assign key_val[1] = req_key_value_1;
   assign key_val[2] = req_key_value_2;
   assign key_val[3] = req_key_value_3;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tmem[wr_addr] <= req_key_time;
      end
      t_rdata_ff <= tmem[t_raddr];
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      last_in   = last_ff;
      i_in      = i_ff;
      prev_in   = prev_ff;
      next_in   = next_ff;
      endt_in   = endt_ff;
      t_in      = t_ff;
      tprev_in  = tprev_ff;
      samp_in   = samp_ff;
      loop_in   = loop_ff;
      blend_in  = blend_ff;
      status_in = status_ff;
      lfac_in   = lfac_ff;
      t_raddr   = i_ff;
      div_start = 1'b0;
      div_dvd   = {16'b0, samp_ff};
      div_dsr   = endt_ff;
      load_out  = 1'b0;
      lctrl     = '0;
      lctrl.we  = mem_we;
      lctrl.blend = blend_ff;
      unique case (state_ff)
         S_IDLE: begin
            t_raddr = KW'(n_cur - NW'(1));
            if (accept) begin
               n_in     = n_cur;
               last_in  = KW'(n_cur - NW'(1));
               samp_in  = req_sample_time;
               loop_in  = req_loop_enable;
               blend_in = 1'b0;
               if (req_opcode == ksi_pkg::OP_WRITE) begin
                  status_in = ksi_pkg::ST_WRITTEN;
                  state_in  = S_OUT;
               end else if (n_cur == '0) begin
                  status_in = ksi_pkg::ST_EMPTY;
                  state_in  = S_OUT;
               end else begin
                  status_in = ksi_pkg::ST_SAMPLED;
                  state_in  = S_END;
               end
            end
         end
         S_END: begin
            endt_in  = t_rdata_ff;
            t_raddr  = '0;
            state_in = S_FIRST;
         end
         S_FIRST: begin
            i_in = '0;
            if (n_ff >= NW'(2) && t_rdata_ff >= endt_ff) begin
               status_in = ksi_pkg::ST_ORDER;
               state_in  = S_OUT;
            end else if (loop_ff) begin
               if (endt_ff == '0) begin
                  t_in     = '0;
                  state_in = S_SRD;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_MOD;
               end
            end else begin
               t_in     = (samp_ff > endt_ff) ? endt_ff : samp_ff;
               state_in = S_SRD;
            end
         end
         S_MOD: begin
            if (div_done) begin
               t_in     = div_rem;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            div_dvd = {t_ff - tprev_ff, 16'b0};
            div_dsr = t_rdata_ff - tprev_ff;
            if (t_ff <= t_rdata_ff) begin
               next_in = i_ff;
               if (i_ff == '0) begin
                  prev_in  = '0;
                  state_in = S_VP;
               end else begin
                  prev_in = i_ff - KW'(1);
                  if (mode_ff == ksi_pkg::MODE_LINEAR) begin
                     blend_in  = 1'b1;
                     div_start = 1'b1;
                     state_in  = S_LDIV;
                  end else begin
                     state_in = S_VP;
                  end
               end
            end else if (i_ff == last_ff) begin
               prev_in  = last_ff;
               next_in  = last_ff;
               state_in = S_VP;
            end else begin
               tprev_in = t_rdata_ff;
               i_in     = i_ff + KW'(1);
               state_in = S_SRD;
            end
         end
         S_LDIV: begin
            if (div_done) begin
               lfac_in  = (div_quo > 48'(ksi_pkg::LFAC_ONE)) ? ksi_pkg::LFAC_ONE
                                                             : div_quo[16:0];
               state_in = S_VP;
            end
         end
         S_VP:   state_in = S_VN;
         S_VN: begin
            lctrl.cap_pv = 1'b1;
            state_in     = S_VC;
         end
         S_VC: begin
            lctrl.cap_nv = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            lctrl.do_diff = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            lctrl.do_mul = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            lctrl.do_add = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic [KW-1:0] lane_raddr;
   assign lane_raddr = (state_ff == S_VN) ? next_ff : prev_ff;

   ksi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   for (genvar c = 0; c < ksi_pkg::OUT_VALUES; c++) begin : g_lane
      if (c < COMPONENTS) begin : g_on
         ksi_lane #(.MAX_KEYS(MAX_KEYS)) u_lane (
            .clock   (clock),
            .ctrl    (lctrl),
            .wr_addr (wr_addr),
            .wr_data (key_val[c]),
            .rd_addr (lane_raddr),
            .lfac    (lfac_ff),
            .value   (lane_val[c])
         );
      end else begin : g_off
         assign lane_val[c] = '0;
      end
   end

   // merge: lanes feed the result register; values zero unless sampled
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         blend_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         blend_ff     <= blend_in;
      end
      n_ff      <= n_in;
      last_ff   <= last_in;
      i_ff      <= i_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      endt_ff   <= endt_in;
      t_ff      <= t_in;
      tprev_ff  <= tprev_in;
      samp_ff   <= samp_in;
      loop_ff   <= loop_in;
      status_ff <= status_in;
      lfac_ff   <= lfac_in;
      if (load_out) begin
         rsp_status_ff <= status_ff;
         for (int c = 0; c < ksi_pkg::OUT_VALUES; c++) begin
            rsp_val_ff[c] <= (status_ff == ksi_pkg::ST_SAMPLED) ? lane_val[c] : '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_value_0 = rsp_val_ff[0];
   assign rsp_value_1 = rsp_val_ff[1];
   assign rsp_value_2 = rsp_val_ff[2];
   assign rsp_value_3 = rsp_val_ff[3];

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == S_MOD || state_ff == S_LDIV))
      else $error("divider busy outside a divide state");
   a_lfac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VP && blend_ff) |-> (lfac_ff <= ksi_pkg::LFAC_ONE))
      else $error("lerp factor above one");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid)
      else $error("result load lost");
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request taken while busy");
endmodule
